// File: src/ile_pkg.sv
package ile_pkg;

  // Request codes carried on the op field.
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_SWAP   = 3'd3,
    OP_FIND   = 3'd4
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADPOS  = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_e;

  // Command broadcast to every cell of the row.
  typedef enum logic [1:0] {
    CMD_NOP    = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_MOVE   = 2'd2,
    CMD_SWAP   = 2'd3
  } cell_cmd_e;

  localparam int unsigned PosBits   = 4;
  localparam int unsigned DataBits  = 32;
  localparam int unsigned IndexBits = 4;
  localparam int unsigned CountBits = 5;

endpackage

// File: src/ile_cell.sv
module ile_cell #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned IDX       = 0
) (
  input  logic                            clk_i,
  input  ile_pkg::cell_cmd_e              cmd_i,
  input  logic [$clog2(CAPACITY)-1:0]     pos_a_i,
  input  logic [$clog2(CAPACITY)-1:0]     pos_b_i,
  input  logic [$clog2(CAPACITY+1)-1:0]   count_i,
  input  logic [WORD_BITS-1:0]            value_i,
  input  logic [WORD_BITS-1:0]            bus_i,
  input  logic [WORD_BITS-1:0]            hold_i,
  input  logic [WORD_BITS-1:0]            left_i,
  output logic [WORD_BITS-1:0]            data_o,
  output logic                            match_o
);
  import ile_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [IdxW-1:0] MyIdx = IdxW'(IDX);
  localparam logic [CntW-1:0] MyCnt = CntW'(IDX);

  logic [WORD_BITS-1:0] entry_q;
  logic [WORD_BITS-1:0] entry_d;
  logic                 at_a;
  logic                 at_b;
  logic                 in_shift;

  assign at_a     = (pos_a_i == MyIdx);
  assign at_b     = (pos_b_i == MyIdx);
  // This cell lies in the run that moves up by one on an insert.
  assign in_shift = (IDX != 0) && (pos_a_i < MyIdx) && (MyCnt <= count_i);

  // Next entry value, chosen by the broadcast command and this cell's place.
  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i)
      CMD_INSERT: begin
        if (at_a) begin
          entry_d = value_i;
        end else if (in_shift) begin
          entry_d = left_i;
        end
      end
      CMD_MOVE: begin
        if (at_a) begin
          entry_d = bus_i;
        end
      end
      CMD_SWAP: begin
        if (at_b) begin
          entry_d = hold_i;
        end else if (at_a) begin
          entry_d = bus_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // The entry holds no reset value; it is written before it is ever read.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign data_o  = entry_q;
  assign match_o = (entry_q == value_i) && (MyCnt < count_i);

endmodule

// File: src/indexed_list_engine_top.sv
// Result: insert, remove, read and rejected requests give their result in the cycle after
// acceptance; swap and find first pass through a second sequencer step (S_SWAP, S_FIND).
// Throughput: one transaction per cycle for single-step requests while the result is not
// stalled; swap and find stall input in their second step, set by the bus and match vector.
// Reset: rst_ni clears the entry count, sequencer and output valid; cell entries are
// not cleared and are unreadable until written.
module indexed_list_engine_top #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        op_i,
  input  logic [ile_pkg::PosBits-1:0]       pos_i,
  input  logic [ile_pkg::PosBits-1:0]       pos_b_i,
  input  logic [ile_pkg::DataBits-1:0]      value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic [ile_pkg::DataBits-1:0]      data_o,
  output logic [ile_pkg::IndexBits-1:0]     index_o,
  output logic [ile_pkg::CountBits-1:0]     count_o
);
  import ile_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > PosBits) ? CntW : PosBits;

  typedef logic [IdxW-1:0]      idx_t;
  typedef logic [CntW-1:0]      cnt_t;
  typedef logic [CmpW-1:0]      cmp_t;
  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWAP,
    S_FIND
  } state_e;

  state_e                state_q, state_d;
  cnt_t                  cnt_q, cnt_d;
  word_t                 hold_q, hold_d;
  idx_t                  pa_q, pa_d;
  idx_t                  pb_q, pb_d;
  logic [CAPACITY-1:0]   match_q, match_d;
  logic                  out_valid_q, out_valid_d;
  status_e               status_q, status_d;
  logic [DataBits-1:0]   data_q, data_d;
  logic [IndexBits-1:0]  index_q, index_d;
  logic [CountBits-1:0]  count_q, count_d;

  cell_cmd_e             cmd;
  idx_t                  cell_pa;
  idx_t                  cell_pb;
  idx_t                  rd_addr;
  word_t                 cell_val;
  word_t                 bus;
  word_t                 cell_data [CAPACITY];
  logic [CAPACITY-1:0]   cell_match;
  logic [CAPACITY-1:0]   first_hit;
  idx_t                  hit_idx;
  logic                  accept;
  logic                  produce;
  status_e               res_status;
  word_t                 res_data;
  idx_t                  res_idx;
  cmp_t                  n_ext;
  cmp_t                  pa_ext;
  cmp_t                  pb_ext;

  // Row of cells; each holds one entry and hands it to its upper neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t left;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_rest
      assign left = cell_data[i-1];
    end
    ile_cell #(
      .CAPACITY (CAPACITY),
      .WORD_BITS(WORD_BITS),
      .IDX      (i)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .pos_a_i(cell_pa),
      .pos_b_i(cell_pb),
      .count_i(cnt_q),
      .value_i(cell_val),
      .bus_i  (bus),
      .hold_i (hold_q),
      .left_i (left),
      .data_o (cell_data[i]),
      .match_o(cell_match[i])
    );
  end

  // Shared read bus: one entry selected by address.
  always_comb begin
    bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      bus = bus | ({WORD_BITS{rd_addr == idx_t'(i)}} & cell_data[i]);
    end
  end

  // First match: isolate the lowest set bit, then encode its position.
  assign first_hit = match_q & (~match_q + 1'b1);
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_idx = hit_idx | ({IdxW{first_hit[i]}} & idx_t'(i));
    end
  end

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign n_ext      = cmp_t'(cnt_q);
  assign pa_ext     = cmp_t'(pos_i);
  assign pb_ext     = cmp_t'(pos_b_i);

  // Sequencer: decodes a transaction, drives the cells and forms the result.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    hold_d      = hold_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    match_d     = match_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    data_d      = data_q;
    index_d     = index_q;
    count_d     = count_q;
    cmd         = CMD_NOP;
    cell_pa     = idx_t'(pos_i);
    cell_pb     = idx_t'(pos_b_i);
    rd_addr     = idx_t'(pos_i);
    cell_val    = word_t'(value_i);
    produce     = 1'b0;
    res_status  = ST_OK;
    res_data    = '0;
    res_idx     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          produce = 1'b1;
          unique case (op_e'(op_i))
            OP_INSERT: begin
              if (pa_ext > n_ext) begin
                res_status = ST_BADPOS;
              end else if (cnt_q == cnt_t'(CAPACITY)) begin
                res_status = ST_FULL;
              end else begin
                cmd   = CMD_INSERT;
                cnt_d = cnt_q + 1'b1;
              end
            end
            OP_REMOVE: begin
              if (pa_ext >= n_ext) begin
                res_status = ST_BADPOS;
              end else begin
                rd_addr = idx_t'(cnt_q - 1'b1);
                cmd     = CMD_MOVE;
                cnt_d   = cnt_q - 1'b1;
              end
            end
            OP_READ: begin
              if (pa_ext >= n_ext) begin
                res_status = ST_BADPOS;
              end else begin
                res_data = bus;
              end
            end
            OP_SWAP: begin
              if ((pa_ext >= n_ext) || (pb_ext >= n_ext)) begin
                res_status = ST_BADPOS;
              end else begin
                produce = 1'b0;
                hold_d  = bus;
                pa_d    = idx_t'(pos_i);
                pb_d    = idx_t'(pos_b_i);
                state_d = S_SWAP;
              end
            end
            OP_FIND: begin
              produce = 1'b0;
              match_d = cell_match;
              state_d = S_FIND;
            end
            default: begin
              res_status = ST_BADPOS;
            end
          endcase
        end
      end
      S_SWAP: begin
        rd_addr = pb_q;
        cell_pa = pa_q;
        cell_pb = pb_q;
        cmd     = CMD_SWAP;
        produce = 1'b1;
        state_d = S_IDLE;
      end
      S_FIND: begin
        produce = 1'b1;
        if (match_q == '0) begin
          res_status = ST_NOMATCH;
        end else begin
          res_idx = hit_idx;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (produce) begin
      out_valid_d = 1'b1;
      status_d    = res_status;
      data_d      = DataBits'(res_data);
      index_d     = IndexBits'(res_idx);
      count_d     = CountBits'(cnt_d);
    end
  end

  // State and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      hold_q      <= '0;
      pa_q        <= '0;
      pb_q        <= '0;
      match_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      data_q      <= '0;
      index_q     <= '0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      hold_q      <= hold_d;
      pa_q        <= pa_d;
      pb_q        <= pb_d;
      match_q     <= match_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      data_q      <= data_d;
      index_q     <= index_d;
      count_q     <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_o      = data_q;
  assign index_o     = index_q;
  assign count_o     = count_q;

endmodule

// File: src/ile_checker.sv
module ile_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [1:0]                    status_o,
  input logic [ile_pkg::DataBits-1:0]  data_o,
  input logic [ile_pkg::IndexBits-1:0] index_o,
  input logic [ile_pkg::CountBits-1:0] count_o
);
  import ile_pkg::*;

  // A held result stays put while the consumer stalls.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(count_o))
    else $error("result changed while stalled");

  // The list never reports more entries than it can hold.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CAPACITY > 31) || (count_o <= CountBits'(CAPACITY)))
    else $error("count beyond capacity");

  // A full status is only given when the list is at capacity.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> count_o == CountBits'(CAPACITY))
    else $error("full status with free space");

  // A failed transaction returns zero data and zero index.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (data_o == '0) && (index_o == '0))
    else $error("failed transaction carries data");

  // A transaction accepted while no result waits is answered, also after a second sequencer step.
  a_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> ##1 out_valid_o || $past(out_valid_o))
    else $error("transaction not answered");

endmodule

bind indexed_list_engine_top ile_checker #(
  .CAPACITY(CAPACITY)
) u_ile_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .status_o   (status_o),
  .data_o     (data_o),
  .index_o    (index_o),
  .count_o    (count_o)
);

// File: dv/tb_indexed_list_engine_top.sv
module tb_indexed_list_engine_top;
  import ile_pkg::*;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned RANDOM_REQUESTS = 850;
  localparam int unsigned IDLE_PERCENT = 11;
  localparam int unsigned QUIET_FIRST = 350;
  localparam int unsigned QUIET_LAST = 500;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Request codes outside the defined set; the block must reject them.
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]          op;
    logic [PosBits-1:0]  pos;
    logic [PosBits-1:0]  pos_b;
    logic [DataBits-1:0] value;
  } list_request_t;

  typedef struct packed {
    status_e              status;
    logic [DataBits-1:0]  data;
    logic [IndexBits-1:0] index;
    logic [CountBits-1:0] count;
  } list_response_t;

  typedef struct packed {
    list_request_t  req;
    logic [4:0]     reps;
    logic           typed;
    list_response_t golden;
  } directed_row_t;

  localparam list_response_t FROM_SHADOW = '{ST_OK, 32'h0, 4'd0, 5'd0};

  // Directed sequence: empty-list rejects, insert at the front and at the end,
  // swap bounds, spare codes, fill to capacity, full and no-match cases.
  localparam int unsigned NUM_ROWS = 26;
  localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{'{OP_READ,     4'd0,  4'd0, 32'h0},        5'd1,  1'b1, '{ST_BADPOS,  32'h0, 4'd0, 5'd0}},
    '{'{OP_REMOVE,   4'd0,  4'd0, 32'h0},        5'd1,  1'b1, '{ST_BADPOS,  32'h0, 4'd0, 5'd0}},
    '{'{OP_SWAP,     4'd0,  4'd0, 32'h0},        5'd1,  1'b1, '{ST_BADPOS,  32'h0, 4'd0, 5'd0}},
    '{'{OP_FIND,     4'd0,  4'd0, 32'h0},        5'd1,  1'b1, '{ST_NOMATCH, 32'h0, 4'd0, 5'd0}},
    '{'{OP_INSERT,   4'd1,  4'd0, 32'h1},        5'd1,  1'b1, '{ST_BADPOS,  32'h0, 4'd0, 5'd0}},
    '{'{OP_SPARE_LO, 4'd0,  4'd0, 32'h1},        5'd1,  1'b1, '{ST_BADPOS,  32'h0, 4'd0, 5'd0}},
    '{'{OP_INSERT,   4'd0,  4'd0, 32'hFFFF_FFFF}, 5'd1, 1'b1, '{ST_OK,      32'h0, 4'd0, 5'd1}},
    '{'{OP_INSERT,   4'd0,  4'd0, 32'h0},        5'd1,  1'b1, '{ST_OK,      32'h0, 4'd0, 5'd2}},
    '{'{OP_INSERT,   4'd2,  4'd0, 32'h8000_0000}, 5'd1, 1'b1, '{ST_OK,      32'h0, 4'd0, 5'd3}},
    '{'{OP_READ,     4'd0,  4'd0, 32'h0},        5'd1,  1'b0, FROM_SHADOW},
    '{'{OP_READ,     4'd1,  4'd0, 32'h0},        5'd1,  1'b0, FROM_SHADOW},
    '{'{OP_FIND,     4'd0,  4'd0, 32'hFFFF_FFFF}, 5'd1, 1'b0, FROM_SHADOW},
    '{'{OP_SWAP,     4'd0,  4'd2, 32'h0},        5'd1,  1'b0, FROM_SHADOW},
    '{'{OP_SWAP,     4'd1,  4'd1, 32'h0},        5'd1,  1'b0, FROM_SHADOW},
    '{'{OP_SWAP,     4'd0,  4'd3, 32'h0},        5'd1,  1'b1, '{ST_BADPOS,  32'h0, 4'd0, 5'd3}},
    '{'{OP_READ,     4'd3,  4'd0, 32'h0},        5'd1,  1'b1, '{ST_BADPOS,  32'h0, 4'd0, 5'd3}},
    '{'{OP_SPARE_HI, 4'd15, 4'd15, 32'hFFFF_FFFF}, 5'd1, 1'b1, '{ST_BADPOS, 32'h0, 4'd0, 5'd3}},
    '{'{OP_REMOVE,   4'd0,  4'd0, 32'h0},        5'd1,  1'b0, FROM_SHADOW},
    '{'{OP_REMOVE,   4'd1,  4'd0, 32'h0},        5'd1,  1'b0, FROM_SHADOW},
    '{'{OP_INSERT,   4'd0,  4'd0, 32'h5A5A_5A5A}, 5'd15, 1'b0, FROM_SHADOW},
    '{'{OP_INSERT,   4'd15, 4'd0, 32'h1},        5'd1,  1'b1, '{ST_FULL,    32'h0, 4'd0, 5'd16}},
    '{'{OP_FIND,     4'd0,  4'd0, 32'h1234_5678}, 5'd1, 1'b1, '{ST_NOMATCH, 32'h0, 4'd0, 5'd16}},
    '{'{OP_FIND,     4'd0,  4'd0, 32'h0},        5'd1,  1'b0, FROM_SHADOW},
    '{'{OP_READ,     4'd15, 4'd0, 32'h0},        5'd1,  1'b0, FROM_SHADOW},
    '{'{OP_REMOVE,   4'd15, 4'd0, 32'h0},        5'd1,  1'b0, FROM_SHADOW},
    '{'{OP_INSERT,   4'd15, 4'd0, 32'hFFFF_FFFF}, 5'd1, 1'b0, FROM_SHADOW}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [2:0]           op_i = '0;
  logic [PosBits-1:0]   pos_i = '0;
  logic [PosBits-1:0]   pos_b_i = '0;
  logic [DataBits-1:0]  value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [1:0]           status_o;
  logic [DataBits-1:0]  data_o;
  logic [IndexBits-1:0] index_o;
  logic [CountBits-1:0] count_o;

  // Shadow copy of the list, kept in step with accepted requests.
  logic [DataBits-1:0]  shadow_words [CAPACITY];
  logic [CountBits-1:0] shadow_count = '0;
  bit                   filling = 1'b1;
  bit                   quiet_stretch = 1'b0;
  list_response_t       pending_responses [$];
  int unsigned          error_count = 0;
  int unsigned          cycle_count = 0;

  indexed_list_engine_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .pos_i       (pos_i),
    .pos_b_i     (pos_b_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_o      (data_o),
    .index_o     (index_o),
    .count_o     (count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one request to the shadow list and returns the response it owes.
  function automatic list_response_t shadow_execute(input list_request_t req);
    list_response_t rsp;
    logic [DataBits-1:0] held;
    int i;
    rsp = '{ST_OK, '0, '0, '0};
    case (req.op)
      OP_INSERT: begin
        if (req.pos > shadow_count) begin
          rsp.status = ST_BADPOS;
        end else if (shadow_count == CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > req.pos; i--) begin
            shadow_words[i] = shadow_words[i-1];
          end
          shadow_words[req.pos] = req.value;
          shadow_count = shadow_count + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (req.pos >= shadow_count) begin
          rsp.status = ST_BADPOS;
        end else begin
          shadow_words[req.pos] = shadow_words[shadow_count-1];
          shadow_words[shadow_count-1] = '0;
          shadow_count = shadow_count - 1'b1;
        end
      end
      OP_READ: begin
        if (req.pos >= shadow_count) begin
          rsp.status = ST_BADPOS;
        end else begin
          rsp.data = shadow_words[req.pos];
        end
      end
      OP_SWAP: begin
        if (req.pos >= shadow_count || req.pos_b >= shadow_count) begin
          rsp.status = ST_BADPOS;
        end else begin
          held = shadow_words[req.pos];
          shadow_words[req.pos] = shadow_words[req.pos_b];
          shadow_words[req.pos_b] = held;
        end
      end
      OP_FIND: begin
        rsp.status = ST_NOMATCH;
        for (i = 0; i < shadow_count; i++) begin
          if (rsp.status == ST_NOMATCH && shadow_words[i] == req.value) begin
            rsp.status = ST_OK;
            rsp.index = IndexBits'(i);
          end
        end
      end
      default: rsp.status = ST_BADPOS;
    endcase
    rsp.count = shadow_count;
    return rsp;
  endfunction

  // A position inside the list when there is one, anywhere otherwise.
  function automatic logic [PosBits-1:0] pick_slot();
    if (shadow_count == 0) return PosBits'($urandom_range(15));
    return PosBits'($urandom_range(shadow_count - 1));
  endfunction

  // Corner words, so that duplicates and bit extremes show up often.
  function automatic logic [DataBits-1:0] corner_word();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return 32'h0000_0001;
      3: return 32'h8000_0000;
      default: return DataBits'($urandom_range(7));
    endcase
  endfunction

  // Random request shaped by the list occupancy: it swings between filling
  // and draining so that the full and empty boundaries are crossed often.
  function automatic list_request_t next_request();
    list_request_t req;
    int unsigned roll;
    req.pos_b = PosBits'($urandom_range(15));
    req.value = $urandom;
    if (shadow_count == 0) begin
      filling = 1'b1;
    end else if (shadow_count == CAPACITY && $urandom_range(3) == 0) begin
      filling = 1'b0;
    end else if ($urandom_range(49) == 0) begin
      filling = ~filling;
    end
    if ($urandom_range(99) < 8) begin
      req.op = 3'($urandom_range(7));
      req.pos = PosBits'($urandom_range(15));
    end else begin
      roll = $urandom_range(99);
      if (roll < (filling ? 40 : 15)) req.op = OP_INSERT;
      else if (roll < 50) req.op = OP_REMOVE;
      else if (roll < 70) req.op = OP_READ;
      else if (roll < 85) req.op = OP_SWAP;
      else req.op = OP_FIND;
      if (req.op == OP_INSERT) begin
        req.pos = PosBits'($urandom_range(shadow_count));
      end else begin
        req.pos = pick_slot();
        req.pos_b = pick_slot();
      end
      if ($urandom_range(9) == 0) req.pos = PosBits'($urandom_range(15));
      if (req.op == OP_FIND && shadow_count != 0 && $urandom_range(2) != 0) begin
        req.value = shadow_words[$urandom_range(shadow_count - 1)];
      end else if ($urandom_range(3) == 0) begin
        req.value = corner_word();
      end
    end
    return req;
  endfunction

  // Offers one transaction, holding it until accepted, and records the response owed.
  task automatic send_request(input list_request_t req, input logic typed,
                              input list_response_t golden);
    list_response_t predicted;
    while (!quiet_stretch && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= req.op;
    pos_i <= req.pos;
    pos_b_i <= req.pos_b;
    value_i <= req.value;
    do @(posedge clk_i); while (in_stall_o);
    predicted = shadow_execute(req);
    pending_responses.push_back(typed ? golden : predicted);
  endtask

  initial begin : stimulus
    list_request_t req;
    int rep;
    int n;
    foreach (shadow_words[i]) shadow_words[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_ROWS[r]) begin
      for (rep = 0; rep < DIRECTED_ROWS[r].reps; rep++) begin
        send_request(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].golden);
      end
    end

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      quiet_stretch = (n >= QUIET_FIRST && n < QUIET_LAST);
      req = next_request();
      send_request(req, 1'b0, FROM_SHADOW);
    end
    quiet_stretch = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_indexed_list_engine_top passed");
    end else begin
      $display("tb_indexed_list_engine_top failed");
    end
    $finish;
  end

  // Compare each accepted response with the oldest one owed, then pick the next stall.
  always @(posedge clk_i) begin : response_check
    list_response_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_responses.size() == 0) begin
        $error("response transaction with none outstanding");
        error_count++;
      end else begin
        want = pending_responses.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
        if (data_o !== want.data) begin
          $error("data: expected %h, got %h", want.data, data_o);
          error_count++;
        end
        if (index_o !== want.index) begin
          $error("index: expected %0d, got %0d", want.index, index_o);
          error_count++;
        end
        if (count_o !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, count_o);
          error_count++;
        end
      end
    end
    out_stall_i <= !quiet_stretch && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_indexed_list_engine_top failed");
      $finish;
    end
  end

endmodule
